// ----- sv/fmbq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and codes for the front-middle-back queue.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MID   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_MID    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_EMPTY = 2'd1;
  localparam logic [1:0] RES_FRONT = 2'd2;
  localparam logic [1:0] RES_BACK  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              f_we;
    logic              f_from_b;
    logic              b_we;
    logic              b_from_f;
    logic [1:0]        res_sel;
    logic [STAT_W-1:0] status;
  } op_t;

endpackage

// ----- sv/front_middle_back_queue_unit.sv -----
`timescale 1ns / 1ps
// An accepted input word is decoded and its ring read issued; the ring write-back
// and the registered result follow when the output register is free or emptied. The
// next input word is taken after that, even while its result still waits.
// Reset clears heads, counts and handshake state; ring contents are not cleared
// and no clearing pass runs, so the unit is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// front_middle_back_queue_unit
// Bounded front/middle/back queue kept as two balanced rings in block memory.
// ----------------------------------------------------------------------------
module front_middle_back_queue_unit import fmbq_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // value
  input  logic [KIND_W-1:0] s_axis_tuser,   // kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // result_value
  output logic [STAT_W-1:0] m_axis_tuser    // status
);

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);

  logic              busy_q, busy_d;
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q, m_data_d;
  logic [STAT_W-1:0] m_user_q;
  logic              accept, exec_fire;
  logic              f_re, b_re;
  logic [AW-1:0]     f_raddr, b_raddr, f_waddr, b_waddr;
  logic [DATA_W-1:0] f_rdata, b_rdata, f_wdata, b_wdata;
  op_t               op;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = busy_q && (!m_valid_q || m_axis_tready);

  fmbq_ctrl #(
    .CAPACITY (CAPACITY),
    .HALF     (HALF),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .kind_i    (s_axis_tuser),
    .value_i   (s_axis_tdata),
    .f_re_o    (f_re),
    .f_raddr_o (f_raddr),
    .b_re_o    (b_re),
    .b_raddr_o (b_raddr),
    .op_o      (op),
    .f_waddr_o (f_waddr),
    .b_waddr_o (b_waddr)
  );

  assign f_wdata = op.f_from_b ? b_rdata : op.value;
  assign b_wdata = op.b_from_f ? f_rdata : op.value;

  fmbq_ram #(
    .DEPTH (HALF),
    .AW    (AW)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && op.f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (accept && f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  fmbq_ram #(
    .DEPTH (HALF),
    .AW    (AW)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && op.b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (accept && b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_comb begin
    unique case (op.res_sel)
      RES_ZERO:  m_data_d = '0;
      RES_EMPTY: m_data_d = '1;
      RES_FRONT: m_data_d = f_rdata;
      RES_BACK:  m_data_d = b_rdata;
      default:   m_data_d = '0;
    endcase
  end

  always_comb begin
    busy_d    = busy_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (exec_fire) begin
      busy_d    = 1'b0;
      m_valid_d = 1'b1;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      m_data_q <= m_data_d;
      m_user_q <= op.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted word did not start execution");

  a_exec_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (m_axis_tvalid && !busy_q))
    else $error("executed word produced no result");

  a_empty_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata == '1))
    else $error("empty pop without all-ones result");

  a_full_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (m_axis_tdata == '0))
    else $error("dropped push with non-zero result");

endmodule

// ----- sv/fmbq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_ram
// Single ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fmbq_ram import fmbq_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fmbq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmbq_ctrl
// Head and count registers, operation decode, ring read issue and the
// registered write-back plan including the rebalancing move.
// ----------------------------------------------------------------------------
module fmbq_ctrl import fmbq_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int HALF     = 512,
  parameter int AW       = 9,
  parameter int CW       = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              f_re_o,
  output logic [AW-1:0]     f_raddr_o,
  output logic              b_re_o,
  output logic [AW-1:0]     b_raddr_o,
  output op_t               op_o,
  output logic [AW-1:0]     f_waddr_o,
  output logic [AW-1:0]     b_waddr_o
);

  localparam int SW = CW + 1;

  logic [AW-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CW-1:0] fc_q, fc_d, bc_q, bc_d;
  op_t           op_q, op_d;
  logic [AW-1:0] f_waddr_q, f_waddr_d, b_waddr_q, b_waddr_d;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(HALF)) begin
      sum = sum - SW'(HALF);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] base);
    return (base == AW'(HALF - 1)) ? '0 : base + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
    return (base == '0) ? AW'(HALF - 1) : base - 1'b1;
  endfunction

  logic [CW-1:0] fc_m1, bc_m1, total;
  logic          full, empty;

  assign fc_m1 = fc_q - 1'b1;
  assign bc_m1 = bc_q - 1'b1;
  assign total = fc_q + bc_q;
  assign full  = (total == CW'(CAPACITY));
  assign empty = (total == '0);

  always_comb begin
    fh_d      = fh_q;
    fc_d      = fc_q;
    bh_d      = bh_q;
    bc_d      = bc_q;
    f_re_o    = 1'b0;
    f_raddr_o = '0;
    b_re_o    = 1'b0;
    b_raddr_o = '0;
    f_waddr_d = '0;
    b_waddr_d = '0;
    op_d          = '0;
    op_d.value    = value_i;
    op_d.res_sel  = RES_ZERO;
    op_d.status   = ST_OK;
    if ((kind_i == KIND_PUSH_FRONT || kind_i == KIND_PUSH_MID ||
         kind_i == KIND_PUSH_BACK) && full) begin
      op_d.status = ST_FULL;
    end else if ((kind_i == KIND_POP_FRONT || kind_i == KIND_POP_MID ||
                  kind_i == KIND_POP_BACK) && empty) begin
      op_d.status  = ST_EMPTY;
      op_d.res_sel = RES_EMPTY;
    end else begin
      unique case (kind_i)
        KIND_PUSH_BACK: begin
          if (fc_q == bc_q) begin
            if (bc_q == '0) begin
              // lands straight in the front half
              op_d.f_we = 1'b1;
              f_waddr_d = fh_q;
              fc_d      = fc_q + 1'b1;
            end else begin
              b_re_o        = 1'b1;
              b_raddr_o     = bh_q;
              op_d.f_we     = 1'b1;
              op_d.f_from_b = 1'b1;
              f_waddr_d     = ring_add(fh_q, fc_q);
              op_d.b_we     = 1'b1;
              b_waddr_d     = ring_add(bh_q, bc_q);
              bh_d          = ring_inc(bh_q);
              fc_d          = fc_q + 1'b1;
            end
          end else begin
            op_d.b_we = 1'b1;
            b_waddr_d = ring_add(bh_q, bc_q);
            bc_d      = bc_q + 1'b1;
          end
        end
        KIND_PUSH_FRONT, KIND_PUSH_MID: begin
          if (fc_q != bc_q) begin
            // front half's last word moves to the back half
            f_re_o        = 1'b1;
            f_raddr_o     = ring_add(fh_q, fc_m1);
            op_d.b_we     = 1'b1;
            op_d.b_from_f = 1'b1;
            b_waddr_d     = ring_dec(bh_q);
            bh_d          = ring_dec(bh_q);
            bc_d          = bc_q + 1'b1;
            op_d.f_we     = 1'b1;
            if (kind_i == KIND_PUSH_FRONT) begin
              f_waddr_d = ring_dec(fh_q);
              fh_d      = ring_dec(fh_q);
            end else begin
              f_waddr_d = ring_add(fh_q, fc_m1);
            end
          end else begin
            op_d.f_we = 1'b1;
            fc_d      = fc_q + 1'b1;
            if (kind_i == KIND_PUSH_FRONT) begin
              f_waddr_d = ring_dec(fh_q);
              fh_d      = ring_dec(fh_q);
            end else begin
              f_waddr_d = ring_add(fh_q, fc_q);
            end
          end
        end
        KIND_POP_FRONT: begin
          f_re_o       = 1'b1;
          f_raddr_o    = fh_q;
          op_d.res_sel = RES_FRONT;
          fh_d         = ring_inc(fh_q);
          if (fc_q == bc_q) begin
            b_re_o        = 1'b1;
            b_raddr_o     = bh_q;
            op_d.f_we     = 1'b1;
            op_d.f_from_b = 1'b1;
            f_waddr_d     = ring_add(fh_q, fc_q);
            bh_d          = ring_inc(bh_q);
            bc_d          = bc_m1;
          end else begin
            fc_d = fc_m1;
          end
        end
        KIND_POP_MID: begin
          f_re_o       = 1'b1;
          f_raddr_o    = ring_add(fh_q, fc_m1);
          op_d.res_sel = RES_FRONT;
          if (fc_q == bc_q) begin
            b_re_o        = 1'b1;
            b_raddr_o     = bh_q;
            op_d.f_we     = 1'b1;
            op_d.f_from_b = 1'b1;
            f_waddr_d     = ring_add(fh_q, fc_m1);
            bh_d          = ring_inc(bh_q);
            bc_d          = bc_m1;
          end else begin
            fc_d = fc_m1;
          end
        end
        KIND_POP_BACK: begin
          if (bc_q != '0) begin
            b_re_o       = 1'b1;
            b_raddr_o    = ring_add(bh_q, bc_m1);
            op_d.res_sel = RES_BACK;
            if (fc_q != bc_q) begin
              f_re_o        = 1'b1;
              f_raddr_o     = ring_add(fh_q, fc_m1);
              op_d.b_we     = 1'b1;
              op_d.b_from_f = 1'b1;
              b_waddr_d     = ring_dec(bh_q);
              bh_d          = ring_dec(bh_q);
              fc_d          = fc_m1;
            end else begin
              bc_d = bc_m1;
            end
          end else begin
            f_re_o       = 1'b1;
            f_raddr_o    = ring_add(fh_q, fc_m1);
            op_d.res_sel = RES_FRONT;
            fc_d         = fc_m1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      fc_q <= '0;
      bh_q <= '0;
      bc_q <= '0;
    end else if (accept_i) begin
      fh_q <= fh_d;
      fc_q <= fc_d;
      bh_q <= bh_d;
      bc_q <= bc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q      <= op_d;
      f_waddr_q <= f_waddr_d;
      b_waddr_q <= b_waddr_d;
    end
  end

  assign op_o      = op_q;
  assign f_waddr_o = f_waddr_q;
  assign b_waddr_o = b_waddr_q;

endmodule
